>>> rtl/nearest_centroid_assign_unit_macros.svh
// ----------------------------------------------------------------------------
// nearest centroid assign unit - assertion macros
// implication checks on the unit clock, masked while reset is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_ASSIGN_UNIT_MACROS_SVH
`define NEAREST_CENTROID_ASSIGN_UNIT_MACROS_SVH

// same-cycle implication
`define NCAU_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ncau same-cycle check failed");

// next-cycle implication
`define NCAU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ncau next-cycle check failed");

`endif

>>> rtl/ncau_pkg.sv
// ----------------------------------------------------------------------------
// ncau_pkg
// shared types and constants of the nearest centroid assign unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncau_pkg;

    // request opcodes
    typedef enum logic {
        CMD_WRITE    = 1'b0,
        CMD_CLASSIFY = 1'b1
    } ncau_cmd_t;

    // control that travels with a request along the chain
    typedef struct packed {
        logic      valid;
        ncau_cmd_t cmd;
    } ncau_ctrl_t;

    // fixed field widths
    localparam int SLOT_W        = 3;
    localparam int IN_COORD_W    = 16;
    localparam int NUM_IN_COORDS = 4;
    localparam int OUT_IDX_W     = 3;
    localparam int DIST_W        = 34;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int ACTIVE_CENTROIDS_W = 4;
    localparam int ACTIVE_DIMS_W      = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_CENTROIDS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_DIMS      = 1'b1;
    localparam logic [ACTIVE_CENTROIDS_W-1:0] ACTIVE_CENTROIDS_RST = 4'd8;
    localparam logic [ACTIVE_DIMS_W-1:0]      ACTIVE_DIMS_RST      = 3'd4;

endpackage

>>> rtl/nearest_centroid_assign_unit.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_unit
// k-means assignment step: a chain of centroid cells that finds the
// nearest stored centroid and its squared distance for each point
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid/s_ready    command, centroid_slot, coord_0..3
//  m_*       out        m_valid/m_ready    nearest_index, min_distance
//  cfg_*     in         cfg_wr_en          cfg_index, cfg_data
//
//  a request walks one cell per cycle unless a result waits on m_ready;
//  a classify result passes one cell register per centroid, then the final
//  compare into the result register on m_*; a new request may enter every
//  cycle on the same condition; write requests move down the same chain, so
//  they stay in order with points; while a result waits on m_ready the whole
//  chain holds still; reset clears the valid flags and sets active_centroids
//  to 8, active_dims to 4; the centroid cells are not cleared
//
`timescale 1ns / 1ps
`include "nearest_centroid_assign_unit_macros.svh"

module nearest_centroid_assign_unit #(
    parameter int MAX_CENTROIDS = 8,
    parameter int MAX_DIMS      = 4,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [2:0]          s_centroid_slot,
    input  logic signed [15:0]  s_coord_0,
    input  logic signed [15:0]  s_coord_1,
    input  logic signed [15:0]  s_coord_2,
    input  logic signed [15:0]  s_coord_3,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_nearest_index,
    output logic [33:0]         m_min_distance,
    // configuration writes
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [3:0]          cfg_data
);
    import ncau_pkg::*;

    localparam int IDX_W  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int KEFF_W = $clog2(MAX_CENTROIDS + 1);
    localparam int DIMS_W = $clog2(MAX_DIMS + 1);
    localparam logic [31:0] MAX_CENTROIDS_U = MAX_CENTROIDS;
    localparam logic [31:0] MAX_DIMS_U      = MAX_DIMS;

    // configuration registers
    logic [ACTIVE_CENTROIDS_W-1:0] active_centroids_reg;
    logic [ACTIVE_DIMS_W-1:0]      active_dims_reg;
    logic [KEFF_W-1:0]             k_eff;
    logic [DIMS_W-1:0]             dims_eff;

    // chain links, link 0 is the request port and link MAX_CENTROIDS the tail
    ncau_ctrl_t                             ctrl_link  [MAX_CENTROIDS+1];
    logic [SLOT_W-1:0]                      slot_link  [MAX_CENTROIDS+1];
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]   point_link [MAX_CENTROIDS+1];
    logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0] sq_link    [MAX_CENTROIDS+1];
    logic [IDX_W-1:0]                       bidx_link  [MAX_CENTROIDS+1];
    logic [DIST_W-1:0]                      bdist_link [MAX_CENTROIDS+1];

    logic [NUM_IN_COORDS-1:0][IN_COORD_W-1:0] in_coords;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]     point_head;
    logic [IDX_W-1:0]   tail_idx;
    logic [DIST_W-1:0]  tail_dist;
    logic [31:0]        tail_idx_ext;
    logic               advance;

    // result register
    logic               m_valid_reg;
    logic [OUT_IDX_W-1:0] m_idx_reg;
    logic [DIST_W-1:0]  m_dist_reg;

    // chain moves whenever the result slot is free or being drained
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // config registers; user must write them only while idle, block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_centroids_reg <= ACTIVE_CENTROIDS_RST;
            active_dims_reg      <= ACTIVE_DIMS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ACTIVE_CENTROIDS: begin
                    active_centroids_reg <= cfg_data[ACTIVE_CENTROIDS_W-1:0];
                end
                CFG_ACTIVE_DIMS: begin
                    active_dims_reg <= cfg_data[ACTIVE_DIMS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp counts: zero acts as one, large values act as the table size
    always_comb begin
        if (active_centroids_reg == '0) begin
            k_eff = KEFF_W'(1);
        end else if (32'(active_centroids_reg) > MAX_CENTROIDS_U) begin
            k_eff = KEFF_W'(MAX_CENTROIDS);
        end else begin
            k_eff = KEFF_W'(active_centroids_reg);
        end
        if (active_dims_reg == '0) begin
            dims_eff = DIMS_W'(1);
        end else if (32'(active_dims_reg) > MAX_DIMS_U) begin
            dims_eff = DIMS_W'(MAX_DIMS);
        end else begin
            dims_eff = DIMS_W'(active_dims_reg);
        end
    end

    // coordinate words: low COORD_WIDTH bits of each field, zero past the
    // field or past the fourth coordinate
    assign in_coords = {s_coord_3, s_coord_2, s_coord_1, s_coord_0};

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            for (int b = 0; b < COORD_WIDTH; b++) begin
                if ((d < NUM_IN_COORDS) && (b < IN_COORD_W)) begin
                    point_head[d][b] = in_coords[d][b];
                end else begin
                    point_head[d][b] = 1'b0;
                end
            end
        end
    end

    assign point_link[0]      = point_head;
    assign ctrl_link[0].valid = s_valid;
    assign ctrl_link[0].cmd   = ncau_cmd_t'(s_command);
    assign slot_link[0]       = s_centroid_slot;
    assign sq_link[0]         = '0;
    assign bidx_link[0]       = '0;
    assign bdist_link[0]      = '0;

    // one cell per centroid entry
    for (genvar i = 0; i < MAX_CENTROIDS; i++) begin : g_cell
        ncau_cell #(
            .INDEX         (i),
            .MAX_CENTROIDS (MAX_CENTROIDS),
            .MAX_DIMS      (MAX_DIMS),
            .COORD_WIDTH   (COORD_WIDTH),
            .IDX_W         (IDX_W),
            .KEFF_W        (KEFF_W),
            .DIMS_W        (DIMS_W)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .advance       (advance),
            .k_eff         (k_eff),
            .dims_eff      (dims_eff),
            .ctrl_in       (ctrl_link[i]),
            .slot_in       (slot_link[i]),
            .point_in      (point_link[i]),
            .sq_in         (sq_link[i]),
            .best_idx_in   (bidx_link[i]),
            .best_dist_in  (bdist_link[i]),
            .ctrl_out      (ctrl_link[i+1]),
            .slot_out      (slot_link[i+1]),
            .point_out     (point_link[i+1]),
            .sq_out        (sq_link[i+1]),
            .best_idx_out  (bidx_link[i+1]),
            .best_dist_out (bdist_link[i+1])
        );
    end

    // final compare for the last centroid
    ncau_pick #(
        .SLOT        (MAX_CENTROIDS - 1),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .KEFF_W      (KEFF_W)
    ) u_tail_pick (
        .k_eff         (k_eff),
        .sq_in         (sq_link[MAX_CENTROIDS]),
        .best_idx_in   (bidx_link[MAX_CENTROIDS]),
        .best_dist_in  (bdist_link[MAX_CENTROIDS]),
        .best_idx_out  (tail_idx),
        .best_dist_out (tail_dist)
    );

    assign tail_idx_ext = 32'(tail_idx);

    // result register; write requests leave the chain without a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= ctrl_link[MAX_CENTROIDS].valid
                        && (ctrl_link[MAX_CENTROIDS].cmd == CMD_CLASSIFY);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_idx_reg  <= tail_idx_ext[OUT_IDX_W-1:0];
            m_dist_reg <= tail_dist;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nearest_index = m_idx_reg;
    assign m_min_distance  = m_dist_reg;

    // a new result comes only from a classify request at the tail
    `NCAU_ASSERT_IMPL(a_result_from_classify, aclk, aresetn, $rose(m_valid_reg), $past(ctrl_link[MAX_CENTROIDS].valid && (ctrl_link[MAX_CENTROIDS].cmd == CMD_CLASSIFY)))
    // a write request leaving the chain never raises a result
    `NCAU_ASSERT_NEXT(a_write_no_result, aclk, aresetn, advance && ctrl_link[MAX_CENTROIDS].valid && (ctrl_link[MAX_CENTROIDS].cmd == CMD_WRITE), !m_valid_reg)
    // the chain freezes while a result waits
    `NCAU_ASSERT_NEXT(a_chain_holds, aclk, aresetn, m_valid_reg && !m_ready, $stable(ctrl_link[MAX_CENTROIDS]) && $stable(bdist_link[MAX_CENTROIDS]))
    // reported index lies among the searched entries
    `NCAU_ASSERT_IMPL(a_index_in_range, aclk, aresetn, m_valid_reg, 32'(m_idx_reg) < 32'(k_eff))

endmodule

>>> rtl/ncau_pick.sv
// ----------------------------------------------------------------------------
// ncau_pick
// sums one centroid's squared terms, saturates, keeps the nearer candidate
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncau_pick #(
    parameter int SLOT        = 0,
    parameter int MAX_DIMS    = 4,
    parameter int COORD_WIDTH = 16,
    parameter int IDX_W       = 3,
    parameter int KEFF_W      = 4
) (
    input  logic [KEFF_W-1:0]                        k_eff,
    input  logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0]   sq_in,
    input  logic [IDX_W-1:0]                         best_idx_in,
    input  logic [ncau_pkg::DIST_W-1:0]              best_dist_in,
    output logic [IDX_W-1:0]                         best_idx_out,
    output logic [ncau_pkg::DIST_W-1:0]              best_dist_out
);
    import ncau_pkg::*;

    localparam int SUM_W = 2 * COORD_WIDTH + $clog2(MAX_DIMS) + 1;
    localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam bit FIRST = (SLOT == 0);

    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] cand_dist;
    logic              take;

    always_comb begin
        sum = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            sum = sum + SUM_W'(sq_in[d]);
        end
        // saturate at the result field maximum
        if (CMP_W'(sum) > CMP_W'(DIST_MAX)) begin
            cand_dist = DIST_MAX;
        end else begin
            cand_dist = DIST_W'(sum);
        end
        // strict less-than, so the lower index keeps a tie
        take = FIRST || ((k_eff > KEFF_W'(SLOT)) && (cand_dist < best_dist_in));
        best_idx_out  = take ? IDX_W'(SLOT) : best_idx_in;
        best_dist_out = take ? cand_dist : best_dist_in;
    end

endmodule

>>> rtl/ncau_cell.sv
// ----------------------------------------------------------------------------
// ncau_cell
// one chain cell: holds one centroid, squares against the passing point,
// and settles the compare for the previous cell's centroid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncau_cell #(
    parameter int INDEX         = 0,
    parameter int MAX_CENTROIDS = 8,
    parameter int MAX_DIMS      = 4,
    parameter int COORD_WIDTH   = 16,
    parameter int IDX_W         = 3,
    parameter int KEFF_W        = 4,
    parameter int DIMS_W        = 3
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     advance,
    input  logic [KEFF_W-1:0]                        k_eff,
    input  logic [DIMS_W-1:0]                        dims_eff,
    input  ncau_pkg::ncau_ctrl_t                     ctrl_in,
    input  logic [ncau_pkg::SLOT_W-1:0]              slot_in,
    input  logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]     point_in,
    input  logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0]   sq_in,
    input  logic [IDX_W-1:0]                         best_idx_in,
    input  logic [ncau_pkg::DIST_W-1:0]              best_dist_in,
    output ncau_pkg::ncau_ctrl_t                     ctrl_out,
    output logic [ncau_pkg::SLOT_W-1:0]              slot_out,
    output logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]     point_out,
    output logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0]   sq_out,
    output logic [IDX_W-1:0]                         best_idx_out,
    output logic [ncau_pkg::DIST_W-1:0]              best_dist_out
);
    import ncau_pkg::*;

    // cell 0 has no earlier centroid, so its compare slot never qualifies
    localparam int PICK_SLOT = (INDEX == 0) ? MAX_CENTROIDS : INDEX - 1;
    localparam logic [31:0] INDEX_U = INDEX;

    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]   centroid_reg;
    ncau_ctrl_t                             ctrl_reg;
    logic [SLOT_W-1:0]                      slot_reg;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]   point_reg;
    logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0] sq_reg;
    logic [MAX_DIMS-1:0][2*COORD_WIDTH-1:0] sq_next;
    logic [IDX_W-1:0]                       best_idx_reg;
    logic [IDX_W-1:0]                       best_idx_next;
    logic [DIST_W-1:0]                      best_dist_reg;
    logic [DIST_W-1:0]                      best_dist_next;
    logic signed [COORD_WIDTH:0]            diff [MAX_DIMS];
    logic [COORD_WIDTH:0]                   mag  [MAX_DIMS];
    logic                                   wr_hit;

    assign wr_hit = ctrl_in.valid && (ctrl_in.cmd == CMD_WRITE) && (32'(slot_in) == INDEX_U);

    // squared differences against this cell's centroid
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            diff[d] = $signed({point_in[d][COORD_WIDTH-1], point_in[d]})
                    - $signed({centroid_reg[d][COORD_WIDTH-1], centroid_reg[d]});
            mag[d]  = diff[d][COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff[d])
                                           : (COORD_WIDTH+1)'(diff[d]);
            if (DIMS_W'(d) < dims_eff) begin
                sq_next[d] = mag[d][COORD_WIDTH-1:0] * mag[d][COORD_WIDTH-1:0];
            end else begin
                sq_next[d] = '0;
            end
        end
    end

    ncau_pick #(
        .SLOT        (PICK_SLOT),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .KEFF_W      (KEFF_W)
    ) u_pick (
        .k_eff         (k_eff),
        .sq_in         (sq_in),
        .best_idx_in   (best_idx_in),
        .best_dist_in  (best_dist_in),
        .best_idx_out  (best_idx_next),
        .best_dist_out (best_dist_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (advance) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            slot_reg      <= slot_in;
            point_reg     <= point_in;
            sq_reg        <= sq_next;
            best_idx_reg  <= best_idx_next;
            best_dist_reg <= best_dist_next;
            if (wr_hit) begin
                centroid_reg <= point_in;
            end
        end
    end

    assign ctrl_out      = ctrl_reg;
    assign slot_out      = slot_reg;
    assign point_out     = point_reg;
    assign sq_out        = sq_reg;
    assign best_idx_out  = best_idx_reg;
    assign best_dist_out = best_dist_reg;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - nearest centroid assign unit testbench
// drives centroid writes and classify requests through the request channel,
// predicts each nearest index and squared distance, and checks every result
// in order while both channels idle and stall at random
// ----------------------------------------------------------------------------

module tb_top;
    import ncau_pkg::*;

    // ------------------------------------------------------------------------
    // run constants
    // ------------------------------------------------------------------------
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int N_CENT         = 8;
    localparam int N_DIM          = NUM_IN_COORDS;
    // one cell register per centroid plus the result register
    localparam int PIPE_LAT       = N_CENT + 1;
    localparam int SETTLE_CYCLES  = 2 * PIPE_LAT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 12;
    localparam int PHASE_ITEMS    = 136;
    localparam int MAX_PRINTED    = 50;

    localparam logic [15:0] C_MIN = 16'h8000;
    localparam logic [15:0] C_MAX = 16'h7fff;

    // ------------------------------------------------------------------------
    // types
    // ------------------------------------------------------------------------
    typedef struct packed {
        ncau_cmd_t        cmd;
        logic [2:0]       slot;
        logic [3:0][15:0] crd;
    } ncau_req_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic [DIST_W-1:0]    sq_dist;
    } assign_t;

    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } row_kind_t;

    // one row of the directed stimulus list
    typedef struct packed {
        row_kind_t              kind;
        ncau_req_t              req;
        logic                   has_want;
        assign_t                want;
        logic [CFG_INDEX_W-1:0] cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_command;
    logic [2:0]             s_centroid_slot;
    logic signed [15:0]     s_coord_0;
    logic signed [15:0]     s_coord_1;
    logic signed [15:0]     s_coord_2;
    logic signed [15:0]     s_coord_3;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_nearest_index;
    logic [33:0]            m_min_distance;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // ------------------------------------------------------------------------
    // predictor state and bookkeeping
    // ------------------------------------------------------------------------
    logic signed [15:0]            cent_tab [0:N_CENT-1][0:N_DIM-1];
    logic [ACTIVE_CENTROIDS_W-1:0] cent_cnt;
    logic [ACTIVE_DIMS_W-1:0]      dim_cnt;

    assign_t   pending_assign_q [$];
    stim_row_t stim_rows [$];

    // quiet phases run with no gaps and no stalls
    bit quiet = 1'b0;

    int n_errors     = 0;
    int n_checked    = 0;
    int n_writes     = 0;
    int n_classify   = 0;
    int n_reg_writes = 0;
    int idle_cycles  = 0;

    // ------------------------------------------------------------------------
    // clock and dut
    // ------------------------------------------------------------------------
    always #CLK_HALF aclk = ~aclk;

    nearest_centroid_assign_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_centroid_slot (s_centroid_slot),
        .s_coord_0       (s_coord_0),
        .s_coord_1       (s_coord_1),
        .s_coord_2       (s_coord_2),
        .s_coord_3       (s_coord_3),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nearest_index (m_nearest_index),
        .m_min_distance  (m_min_distance),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // nearest centroid predictor
    // ------------------------------------------------------------------------
    // walks the active entries, sums squares over the active coordinates with
    // saturation, keeps the first strict minimum so the lowest index wins ties
    function automatic assign_t nearest_of(input ncau_req_t p);
        int                 k;
        int                 nd;
        int                 c;
        int                 d;
        longint             diff;
        longint             sq;
        longint             acc;
        longint             best;
        longint             cap;
        logic signed [15:0] pc;
        assign_t            res;
        cap = longint'(DIST_MAX);
        // out of range counts clamp to 1 .. max
        k  = int'(cent_cnt);
        nd = int'(dim_cnt);
        if (k == 0) k = 1;
        if (k > N_CENT) k = N_CENT;
        if (nd == 0) nd = 1;
        if (nd > N_DIM) nd = N_DIM;
        best    = 0;
        res.idx = '0;
        for (c = 0; c < k; c++) begin
            acc = 0;
            for (d = 0; d < nd; d++) begin
                pc   = p.crd[d];
                diff = longint'(pc) - longint'(cent_tab[c][d]);
                if (diff < 0) diff = -diff;
                sq = diff * diff;
                if (sq > cap || acc > cap - sq) begin
                    acc = cap;
                end else begin
                    acc = acc + sq;
                end
            end
            if (c == 0 || acc < best) begin
                best    = acc;
                res.idx = c[OUT_IDX_W-1:0];
            end
        end
        res.sq_dist = best[DIST_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------------
    // extremes, full range and small values around zero
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return C_MIN;
            1: return C_MAX;
            2, 3, 4, 5: return 16'($urandom);
            default: return 16'($urandom_range(0, 255)) - 16'd128;
        endcase
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 12);
        else return $urandom_range(25, 70);
    endfunction

    // writes sometimes copy a stored entry to build ties; points often sit
    // close to a stored centroid so the nearest choice is not trivial
    function automatic ncau_req_t random_req();
        ncau_req_t   r;
        int          src;
        int          d;
        bit          copy_entry;
        bit          near;
        logic [15:0] off;
        src        = $urandom_range(0, N_CENT - 1);
        r.slot     = 3'($urandom_range(0, 7));
        copy_entry = ($urandom_range(0, 99) < 20);
        near       = ($urandom_range(0, 99) < 40);
        if ($urandom_range(0, 99) < 25) begin
            r.cmd = CMD_WRITE;
            for (d = 0; d < N_DIM; d++) begin
                if (copy_entry) r.crd[d] = cent_tab[src][d];
                else r.crd[d] = rand_coord();
            end
        end else begin
            r.cmd = CMD_CLASSIFY;
            for (d = 0; d < N_DIM; d++) begin
                off = 16'($urandom_range(0, 16)) - 16'd8;
                if (near) r.crd[d] = cent_tab[src][d] + off;
                else r.crd[d] = rand_coord();
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // directed list builders
    // ------------------------------------------------------------------------
    task automatic add_req(input ncau_cmd_t cmd, input logic [2:0] slot,
                           input logic [15:0] c0, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [15:0] c3,
                           input logic chk, input logic [2:0] wi,
                           input logic [33:0] wd);
        stim_row_t row;
        row.kind         = ROW_REQ;
        row.req.cmd      = cmd;
        row.req.slot     = slot;
        row.req.crd[0]   = c0;
        row.req.crd[1]   = c1;
        row.req.crd[2]   = c2;
        row.req.crd[3]   = c3;
        row.has_want     = chk;
        row.want.idx     = wi;
        row.want.sq_dist = wd;
        row.cfg_idx      = '0;
        row.cfg_val      = '0;
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row          = '0;
        row.kind     = ROW_CFG;
        row.req.cmd  = CMD_WRITE;
        row.cfg_idx  = idx;
        row.cfg_val  = val;
        stim_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // request channel driver
    // ------------------------------------------------------------------------
    // valid is lowered only for a gap or a drain, so back to back requests keep
    // it high across the accepting edge
    task automatic send_req(input ncau_req_t r, input logic has_want,
                            input assign_t want);
        int gap;
        int d;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= r.cmd;
        s_centroid_slot <= r.slot;
        s_coord_0       <= r.crd[0];
        s_coord_1       <= r.crd[1];
        s_coord_2       <= r.crd[2];
        s_coord_3       <= r.crd[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // request accepted at this edge: update the table or queue a result
        if (r.cmd == CMD_WRITE) begin
            for (d = 0; d < N_DIM; d++) cent_tab[r.slot][d] = r.crd[d];
            n_writes++;
        end else begin
            if (has_want) pending_assign_q.push_back(want);
            else pending_assign_q.push_back(nearest_of(r));
            n_classify++;
        end
    endtask

    // let every result come out, then give trailing writes time to pass
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_assign_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register writes only happen with the chain empty
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain_and_settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ACTIVE_CENTROIDS) cent_cnt = val[ACTIVE_CENTROIDS_W-1:0];
        else dim_cnt = val[ACTIVE_DIMS_W-1:0];
        n_reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("[%0t] mismatch at result %0d: %s got %0d want %0d",
                     $time, n_checked, what, got, want);
    endtask

    // compare each accepted result with the oldest pending one
    always @(posedge aclk) begin
        assign_t head;
        if (aresetn && m_valid && m_ready) begin
            if (pending_assign_q.size() == 0) begin
                report_mismatch("result with no classify pending, index",
                                longint'(m_nearest_index), -1);
            end else begin
                head = pending_assign_q.pop_front();
                if (m_nearest_index !== head.idx)
                    report_mismatch("nearest_index", longint'(m_nearest_index),
                                    longint'(head.idx));
                if (m_min_distance !== head.sq_dist)
                    report_mismatch("min_distance", longint'(m_min_distance),
                                    longint'(head.sq_dist));
            end
            n_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any handshake or register write
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles with no progress, %0d results pending",
                     idle_cycles, pending_assign_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result channel backpressure
    // ------------------------------------------------------------------------
    // ready holds each level for a random stretch; stalls mostly short
    initial begin
        int len;
        int r;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (quiet || r < 70) begin
                m_ready <= 1'b1;
                len = $urandom_range(1, 8);
            end else begin
                m_ready <= 1'b0;
                if (r < 95) len = $urandom_range(1, 3);
                else if (r < 99) len = $urandom_range(4, 12);
                else len = $urandom_range(30, 80);
            end
            repeat (len) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        int i;
        int nc;
        int nd;
        int preset_nc [0:5];
        int preset_nd [0:5];
        stim_row_t row;

        // register settings for the first phases: defaults, minimum,
        // zero counts, all-ones counts and mixed extremes
        preset_nc = '{8, 1, 0, 15, 1, 8};
        preset_nd = '{4, 1, 0, 7, 4, 1};

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_WRITE;
        s_centroid_slot = '0;
        s_coord_0       = '0;
        s_coord_1       = '0;
        s_coord_2       = '0;
        s_coord_3       = '0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        cent_cnt        = ACTIVE_CENTROIDS_RST;
        dim_cnt         = ACTIVE_DIMS_RST;

        // directed list: fill every entry first so no classify ever reads
        // an entry that was never written
        add_req(CMD_WRITE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd1, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd2, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd3, 16'd100, 16'd100, 16'd100, 16'd100,
                1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd4, 16'hffff, 16'd1, 16'hffff, 16'd1,
                1'b0, 3'd0, 34'd0);
        // same as entry 3, so entry 3 must win the tie
        add_req(CMD_WRITE, 3'd5, 16'd100, 16'd100, 16'd100, 16'd100,
                1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd6, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 3'd0, 34'd0);
        add_req(CMD_WRITE, 3'd7, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0, 3'd0, 34'd0);
        // reset settings: all eight entries, all four coordinates
        add_req(CMD_CLASSIFY, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 3'd0, 34'd0);
        add_req(CMD_CLASSIFY, 3'd7, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 3'd1, 34'd0);
        add_req(CMD_CLASSIFY, 3'd5, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, 3'd2, 34'd0);
        add_req(CMD_CLASSIFY, 3'd0, 16'd100, 16'd100, 16'd100, 16'd100,
                1'b1, 3'd3, 34'd0);
        // equal nonzero distance to entries 3 and 5
        add_req(CMD_CLASSIFY, 3'd2, 16'd110, 16'd100, 16'd100, 16'd100,
                1'b0, 3'd0, 34'd0);
        add_req(CMD_CLASSIFY, 3'd3, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1, 3'd6, 34'd0);
        // one coordinate only: entries 2 and 7 tie at zero
        add_cfg(CFG_ACTIVE_DIMS, 4'd1);
        add_req(CMD_CLASSIFY, 3'd1, C_MIN, 16'd0, 16'd0, 16'd0, 1'b1, 3'd2, 34'd0);
        // zero counts behave as one entry and one coordinate
        add_cfg(CFG_ACTIVE_DIMS, 4'd0);
        add_cfg(CFG_ACTIVE_CENTROIDS, 4'd0);
        add_req(CMD_CLASSIFY, 3'd6, 16'd5, 16'd1000, 16'd1000, 16'd1000,
                1'b1, 3'd0, 34'd25);
        // counts above the table size clamp to the maximum
        add_cfg(CFG_ACTIVE_DIMS, 4'd7);
        add_cfg(CFG_ACTIVE_CENTROIDS, 4'd15);
        add_req(CMD_CLASSIFY, 3'd4, C_MAX, C_MIN, C_MAX, C_MIN, 1'b1, 3'd6, 34'd0);
        // largest reachable distance with a single far entry
        add_cfg(CFG_ACTIVE_DIMS, 4'd4);
        add_cfg(CFG_ACTIVE_CENTROIDS, 4'd1);
        add_req(CMD_WRITE, 3'd0, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 3'd0, 34'd0);
        add_req(CMD_CLASSIFY, 3'd0, C_MAX, C_MAX, C_MAX, C_MAX,
                1'b1, 3'd0, 34'd17179344900);
        add_req(CMD_WRITE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 3'd0, 34'd0);
        add_cfg(CFG_ACTIVE_CENTROIDS, 4'd8);
        add_req(CMD_CLASSIFY, 3'd5, 16'd1234, 16'hd7d2, 16'd9012, 16'hf280,
                1'b0, 3'd0, 34'd0);
        // classify right behind the write it depends on
        add_req(CMD_WRITE, 3'd3, 16'd7, 16'd7, 16'd7, 16'd7, 1'b0, 3'd0, 34'd0);
        add_req(CMD_CLASSIFY, 3'd0, 16'd7, 16'd7, 16'd7, 16'd7, 1'b1, 3'd3, 34'd0);

        // single reset at the start of the run
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) write_reg(row.cfg_idx, row.cfg_val);
            else send_req(row.req, row.has_want, row.want);
        end

        // random phases, each under its own register setting; the drain
        // before each setting also pauses the sender until all results are in
        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 6) begin
                nc = preset_nc[ph];
                nd = preset_nd[ph];
            end else begin
                nc = $urandom_range(0, 15);
                nd = $urandom_range(0, 15);
            end
            write_reg(CFG_ACTIVE_CENTROIDS, nc[CFG_DATA_W-1:0]);
            write_reg(CFG_ACTIVE_DIMS, nd[CFG_DATA_W-1:0]);
            quiet = (ph % 4 == 3);
            for (i = 0; i < PHASE_ITEMS; i++) send_req(random_req(), 1'b0, '0);
        end
        quiet = 1'b0;

        // wait out the remaining results and the tail of the chain
        drain_and_settle();

        $display("covered %0d centroid writes, %0d classify requests, %0d register writes",
                 n_writes, n_classify, n_reg_writes);
        $display("compared %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
